// File: sv/gha_pkg.sv
package gha_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned WIN_W           = 32;
  localparam int unsigned OFF_W           = 3;
  localparam int unsigned SCRAMBLER_SPAN  = 43;
  localparam logic [WIN_W-1:0] HUNT_PATTERN_RESET = 32'hB6AB31E0;

  // lock event handed from the hunter to the realigner
  typedef struct packed {
    logic              hit;
    logic [OFF_W-1:0]  offset;
    logic [BYTE_W-1:0] leftover;
  } lock_t;

endpackage

// File: sv/gha_in_if.sv
interface gha_in_if;
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// File: sv/gha_out_if.sv
interface gha_out_if;
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::BYTE_W-1:0]  plain_byte;

  modport source (output valid, output plain_byte, input ready);
  modport sink   (input valid, input plain_byte, output ready);
endinterface

// File: sv/gfp_hunt_align_descrambler.sv
// channel   dir  payload            meaning
// in_i      in   data_byte [7:0]    raw line byte, lsb received first
// out_o     out  plain_byte [7:0]   aligned descrambled byte, first bit in msb
// cfg       in   cfg_wdata_i[31:0]  hunt pattern, written when cfg_we_i is high
//
// one byte per cycle sustained while the output accepts; a request passes
// through the input register and one logic stage into the result register
// bytes taken while hunting and the locking byte give no result
// reset clears to hunting with pattern 0xB6AB31E0 and zero descrambler history
// a stalled result holds in the output register; input stalls only when both
// the input register and the result register are full
module gfp_hunt_align_descrambler #(
  parameter int unsigned SCRAMBLER_SPAN = gha_pkg::SCRAMBLER_SPAN
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gha_in_if.sink                      in_i,
  gha_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [gha_pkg::WIN_W-1:0]   cfg_wdata_i
);

  logic [gha_pkg::WIN_W-1:0]  pattern_q;
  logic                       s1_valid_q;
  logic [gha_pkg::BYTE_W-1:0] s1_data_q;
  logic                       out_valid_q;
  logic [gha_pkg::BYTE_W-1:0] out_data_q;
  logic                       locked;
  logic                       out_free;
  logic                       adv;
  logic [gha_pkg::BYTE_W-1:0] plain;
  gha_pkg::lock_t             lock;

  assign out_free   = !out_valid_q || out_o.ready;
  assign adv        = s1_valid_q && (!locked || out_free);
  assign in_i.ready = !s1_valid_q || adv;

  gha_hunt u_hunt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv && !locked),
    .data_i    (s1_data_q),
    .pattern_i (pattern_q),
    .locked_o  (locked),
    .lock_o    (lock)
  );

  gha_descr #(
    .SCRAMBLER_SPAN (SCRAMBLER_SPAN)
  ) u_descr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv && locked),
    .lock_i  (lock),
    .data_i  (s1_data_q),
    .plain_o (plain)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q   <= gha_pkg::HUNT_PATTERN_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pattern_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (adv && locked) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_data_q <= in_i.data_byte;
    end
    if (adv && locked) begin
      out_data_q <= plain;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.plain_byte = out_data_q;

  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked |=> locked)
    else $error("lock dropped without reset");

  a_no_result_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> locked)
    else $error("result produced while hunting");

  a_locked_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && locked |=> out_valid_q)
    else $error("locked byte did not reach the result register");

  a_held_byte_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_data_q))
    else $error("pending input byte lost");

endmodule

// File: sv/gha_hunt.sv
module gha_hunt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [gha_pkg::BYTE_W-1:0]  data_i,
  input  logic [gha_pkg::WIN_W-1:0]   pattern_i,
  output logic                        locked_o,
  output gha_pkg::lock_t              lock_o
);

  localparam int unsigned ExtW = gha_pkg::WIN_W + gha_pkg::BYTE_W;

  logic [gha_pkg::WIN_W-1:0] window_q, window_d;
  logic                      locked_q, locked_d;
  logic [ExtW-1:0]           ext;
  logic [gha_pkg::WIN_W-1:0] cand [gha_pkg::BYTE_W];
  gha_pkg::lock_t            lock;
  logic [gha_pkg::WIN_W-1:0] hit_win;

  // window followed by the byte bit-reversed, so bit 0 of the byte enters first
  always_comb begin
    ext[ExtW-1:gha_pkg::BYTE_W] = window_q;
    for (int b = 0; b < gha_pkg::BYTE_W; b++) begin
      ext[gha_pkg::BYTE_W-1-b] = data_i[b];
    end
  end

  always_comb begin
    lock     = '0;
    hit_win  = ext[gha_pkg::WIN_W-1:0];
    // search from the last bit down so the earliest match wins
    for (int k = gha_pkg::BYTE_W - 1; k >= 0; k--) begin
      cand[k] = gha_pkg::WIN_W'(ext >> (gha_pkg::BYTE_W - 1 - k));
      if (cand[k] == pattern_i) begin
        lock.hit      = 1'b1;
        lock.offset   = gha_pkg::OFF_W'(k + 1);
        lock.leftover = data_i & gha_pkg::BYTE_W'(16'h00FF << (k + 1));
        hit_win       = cand[k];
      end
    end
  end

  always_comb begin
    window_d = window_q;
    locked_d = locked_q;
    if (step_i && !locked_q) begin
      window_d = hit_win;
      locked_d = lock.hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      locked_q <= 1'b0;
    end else begin
      window_q <= window_d;
      locked_q <= locked_d;
    end
  end

  assign locked_o = locked_q;
  assign lock_o   = '{hit: lock.hit && step_i && !locked_q,
                      offset: lock.offset, leftover: lock.leftover};

endmodule

// File: sv/gha_descr.sv
module gha_descr #(
  parameter int unsigned SCRAMBLER_SPAN = gha_pkg::SCRAMBLER_SPAN
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  gha_pkg::lock_t              lock_i,
  input  logic [gha_pkg::BYTE_W-1:0]  data_i,
  output logic [gha_pkg::BYTE_W-1:0]  plain_o
);

  localparam int unsigned ExtW = SCRAMBLER_SPAN + gha_pkg::BYTE_W;

  logic [gha_pkg::OFF_W-1:0]  offset_q, offset_d;
  logic [gha_pkg::BYTE_W-1:0] leftover_q, leftover_d;
  logic [SCRAMBLER_SPAN-1:0]  hist_q, hist_d;
  logic [gha_pkg::BYTE_W-1:0] aligned;
  logic [ExtW-1:0]            ext;
  logic [3:0]                 up_sh;

  assign up_sh = 4'(gha_pkg::BYTE_W) - {1'b0, offset_q};

  always_comb begin
    if (offset_q == '0) begin
      aligned = data_i;
    end else begin
      aligned = gha_pkg::BYTE_W'((16'(leftover_q) >> offset_q) | (16'(data_i) << up_sh));
    end
  end

  // stream of history (oldest at bit 0) then the new bits; tap is span bits back
  assign ext = {aligned, hist_q};

  always_comb begin
    for (int j = 0; j < gha_pkg::BYTE_W; j++) begin
      plain_o[gha_pkg::BYTE_W-1-j] = aligned[j] ^ ext[j];
    end
  end

  always_comb begin
    offset_d   = offset_q;
    leftover_d = leftover_q;
    hist_d     = hist_q;
    if (lock_i.hit) begin
      offset_d   = lock_i.offset;
      leftover_d = lock_i.leftover;
    end else if (step_i) begin
      leftover_d = (offset_q == '0) ? '0
                 : data_i & gha_pkg::BYTE_W'(16'h00FF << offset_q);
      hist_d     = ext[ExtW-1:gha_pkg::BYTE_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      leftover_q <= '0;
      hist_q     <= '0;
    end else begin
      offset_q   <= offset_d;
      leftover_q <= leftover_d;
      hist_q     <= hist_d;
    end
  end

endmodule
